FILE: rtl/orbit_camera_position_core_defines.svh
// Assertion macros for the orbit camera position core.
`ifndef ORBIT_CAMERA_POSITION_CORE_DEFINES_SVH
`define ORBIT_CAMERA_POSITION_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define OCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define OCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ocp_pkg.sv
// Shared types and constants for the orbit camera position core.
package ocp_pkg;

  localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C3 = 32'sd693598669;
  localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
  localparam logic signed [31:0] SIN_C7 = 32'sd5026996;
  localparam logic signed [31:0] SIN_C9 = 32'sd172272;
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] REG_ROT  = 2'd0;
  localparam logic [1:0] REG_ZOOM = 2'd1;
  localparam logic [1:0] REG_MIN  = 2'd2;

  // Multiplier operand select codes.
  localparam logic [3:0] MS_ZOOM1 = 4'd0;
  localparam logic [3:0] MS_ZOOM2 = 4'd1;
  localparam logic [3:0] MS_POL1  = 4'd2;
  localparam logic [3:0] MS_POL2  = 4'd3;
  localparam logic [3:0] MS_AZ1   = 4'd4;
  localparam logic [3:0] MS_AZ2   = 4'd5;
  localparam logic [3:0] MS_SQ    = 4'd6;
  localparam logic [3:0] MS_HORN  = 4'd7;
  localparam logic [3:0] MS_HLAST = 4'd8;
  localparam logic [3:0] MS_PA    = 4'd9;
  localparam logic [3:0] MS_PB    = 4'd10;
  localparam logic [3:0] MS_DX    = 4'd11;
  localparam logic [3:0] MS_DY    = 4'd12;
  localparam logic [3:0] MS_DZ    = 4'd13;

  typedef struct packed {
    logic       load;      // latch input item
    logic       mul_en;    // run multiplier with sel
    logic [3:0] mul_sel;
    logic       sin_start; // begin polynomial for angle index
    logic [1:0] sin_idx;   // 0 sinA 1 cosA 2 sinP 3 cosP
    logic [2:0] horn_step; // Horner step number
    logic       out_load;  // write output register
  } ocp_cmd_t;

  typedef struct packed {
    logic out_full;
  } ocp_status_t;

endpackage

FILE: rtl/ocp_ctrl.sv
// Sequencer for the orbit camera position core.
module ocp_ctrl
  import ocp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ocp_status_t status,
  output ocp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_SIN  = 3'd2;
  localparam logic [2:0] ST_EYE  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] step, step_next;
  logic [1:0] idx, idx_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    idx_next   = idx;
    cmd        = '0;
    cmd.sin_idx = idx;
    cmd.horn_step = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_UPD;
          step_next  = '0;
        end
      end
      ST_UPD: begin
        // zoom, polar, azimuth: two multiplies each
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_ZOOM1 + {1'b0, step};
        if (step == 3'd5) begin
          state_next = ST_SIN;
          step_next  = '0;
          idx_next   = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_SIN: begin
        // step 0: x^2, 1..4: Horner, 5: final times x
        cmd.mul_en = 1'b1;
        cmd.sin_start = (step == 3'd0);
        priority if (step == 3'd0) cmd.mul_sel = MS_SQ;
        else if (step == 3'd5) cmd.mul_sel = MS_HLAST;
        else cmd.mul_sel = MS_HORN;
        if (step == 3'd5) begin
          step_next = '0;
          if (idx == 2'd3) state_next = ST_EYE;
          idx_next = idx + 2'd1;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_EYE: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_PA + {1'b0, step};
        if (step == 3'd4) begin
          state_next = ST_OUT;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_OUT: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/ocp_datapath.sv
// Shared multiplier datapath: angle update, sine polynomial, eye products.
module ocp_datapath
  import ocp_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ocp_cmd_t           cmd,
  input  logic [15:0]        rotation_gain,
  input  logic [15:0]        zoom_gain,
  input  logic [30:0]        min_distance,
  input  logic signed [15:0] mouse_dx,
  input  logic signed [15:0] mouse_dy,
  input  logic signed [15:0] wheel_offset,
  input  logic [15:0]        frame_time,
  input  logic               target_present,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic signed [31:0] eye_x,
  output logic signed [31:0] eye_y,
  output logic signed [31:0] eye_z
);

  localparam int ASHIFT = 24 - ANGLE_BITS;
  localparam longint MARGIN_RAW =
    ((64'sd1 << ANGLE_BITS) * 64'sd1000000 + 64'sd3141592653) / 64'sd6283185307;
  localparam longint MARGIN = (MARGIN_RAW < 1) ? 1 : MARGIN_RAW;
  localparam logic signed [ANGLE_BITS-1:0] CAP =
    ANGLE_BITS'((64'sd1 <<< (ANGLE_BITS - 2)) - MARGIN);

  // Item registers
  logic signed [15:0] dx, dy, wh;
  logic [15:0]        dt;
  logic               tp;
  logic signed [31:0] tx, ty, tz;

  // State
  logic [ANGLE_BITS-1:0]        azimuth;
  logic signed [ANGLE_BITS-1:0] polar;
  logic [30:0]                  distance;

  // Work registers
  logic signed [33:0] t1;          // first product of a zoom or angle step
  logic signed [31:0] x;           // quarter-wave argument, Q30
  logic signed [31:0] x2;
  logic signed [31:0] p;
  logic               neg;
  logic signed [31:0] sa, ca, sp, cp;
  logic signed [31:0] pa, pb;
  logic signed [33:0] ex, ey, ez;

  // Sine argument from the angle index
  logic [31:0]        turns;
  logic signed [31:0] x_in;
  logic               neg_in;

  // Shared multiplier: signed 35 x 34 operands kept near 32 bits
  logic signed [34:0] ma;
  logic signed [33:0] mb;
  logic signed [68:0] prod;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_sel)
      MS_ZOOM1: begin ma = -35'(wh); mb = 34'(zoom_gain); end
      MS_POL1:  begin ma = 35'(dy);  mb = 34'(rotation_gain); end
      MS_AZ1:   begin ma = 35'(dx);  mb = 34'(rotation_gain); end
      MS_ZOOM2, MS_POL2, MS_AZ2: begin ma = 35'(t1); mb = 34'(dt); end
      MS_SQ:    begin ma = 35'(x_in); mb = 34'(x_in); end
      MS_HORN:  begin ma = 35'(p); mb = 34'(x2); end
      MS_HLAST: begin ma = 35'(p); mb = 34'(x); end
      MS_PA:    begin ma = 35'(cp); mb = 34'(ca); end
      MS_PB:    begin ma = 35'(cp); mb = 34'(sa); end
      MS_DX:    begin ma = 35'(pa); mb = 34'(distance); end
      MS_DY:    begin ma = 35'(sp); mb = 34'(distance); end
      MS_DZ:    begin ma = 35'(pb); mb = 34'(distance); end
      default:  begin ma = '0; mb = '0; end
    endcase
    prod = 69'(ma) * 69'(mb);
  end

  always_comb begin
    unique case (cmd.sin_idx)
      2'd0: turns = {azimuth, {(32-ANGLE_BITS){1'b0}}};
      2'd1: turns = {azimuth, {(32-ANGLE_BITS){1'b0}}} + 32'h4000_0000;
      2'd2: turns = {polar, {(32-ANGLE_BITS){1'b0}}};
      default: turns = {polar, {(32-ANGLE_BITS){1'b0}}} + 32'h4000_0000;
    endcase
    x_in   = turns[30] ? (32'sh4000_0000 - 32'($signed({2'b00, turns[29:0]})))
                       : 32'($signed({2'b00, turns[29:0]}));
    neg_in = turns[31];
  end

  // Horner constants
  logic signed [31:0] hc;
  always_comb begin
    unique case (cmd.horn_step)
      3'd1: hc = -SIN_C7;
      3'd2: hc = SIN_C5;
      3'd3: hc = -SIN_C3;
      default: hc = SIN_C1;
    endcase
  end

  // Clamp sums
  logic signed [47:0] dsum;
  logic signed [49:0] asum;
  logic signed [68:0] sh30, rnd30, flr_ang;
  logic signed [31:0] psat;

  always_comb begin
    sh30    = prod >>> 30;
    rnd30   = (prod + 69'sd536870912) >>> 30;
    flr_ang = prod >>> ASHIFT;
    dsum = 48'($signed({1'b0, distance})) + 48'(prod >>> 8);
    asum = 50'(polar) + 50'(flr_ang);
    psat = (sh30 < 0) ? 32'sd0 : ((sh30 > 69'sd1073741824) ? 32'sh4000_0000 : 32'(sh30));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      azimuth  <= '0;
      polar    <= '0;
      distance <= 31'd65536;
    end else begin
      if (cmd.load) begin
        dx <= mouse_dx; dy <= mouse_dy; wh <= wheel_offset; dt <= frame_time;
        tp <= target_present; tx <= target_x; ty <= target_y; tz <= target_z;
      end
      if (cmd.mul_en) begin
        unique case (cmd.mul_sel)
          MS_ZOOM1, MS_POL1, MS_AZ1: t1 <= 34'(prod);
          MS_ZOOM2: begin
            priority if (dsum < 48'($signed({1'b0, min_distance})))
              distance <= min_distance;
            else if (dsum > 48'($signed({1'b0, DIST_MAX}))) distance <= DIST_MAX;
            else distance <= 31'(dsum);
          end
          MS_POL2: begin
            priority if (asum > 50'(CAP)) polar <= CAP;
            else if (asum < -50'(CAP)) polar <= -CAP;
            else polar <= ANGLE_BITS'(asum);
          end
          MS_AZ2: azimuth <= azimuth + ANGLE_BITS'(flr_ang);
          MS_SQ: begin
            x   <= x_in;
            neg <= neg_in;
            x2  <= 32'(sh30);
            p   <= SIN_C9;
          end
          MS_HORN: p <= hc + 32'(sh30);
          MS_HLAST: begin
            unique case (cmd.sin_idx)
              2'd0: sa <= neg ? -psat : psat;
              2'd1: ca <= neg ? -psat : psat;
              2'd2: sp <= neg ? -psat : psat;
              default: cp <= neg ? -psat : psat;
            endcase
          end
          MS_PA: pa <= 32'(rnd30);
          MS_PB: pb <= 32'(rnd30);
          MS_DX: ex <= 34'(rnd30) + (tp ? 34'(tx) : 34'sd0);
          MS_DY: ey <= 34'(rnd30) + (tp ? 34'(ty) : 34'sd0);
          MS_DZ: ez <= 34'(rnd30) + (tp ? 34'(tz) : 34'sd0);
          default: ;
        endcase
      end
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -34'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  assign eye_x = sat32(ex);
  assign eye_y = sat32(ey);
  assign eye_z = sat32(ez);

endmodule

FILE: rtl/orbit_camera_position_core.sv
// Top level of the orbit camera position core.
// Usage:
//   s_axis carries one frame item: mouse deltas, wheel offset, frame time,
//   target flag (tuser) and target position. m_axis returns the eye position.
//   Registers rotation_gain (0x0), zoom_gain (0x4), min_distance (0x8) are
//   written by the user over the APB port while the core is idle, unchecked.
// Operation:
//   One item at a time, as a sequence of multiplies:
//   6 multiplies for the angle/zoom update, 6 per sine over four sines,
//   5 for the eye products, all on one shared multiplier.
//   Next item accepted after the result is loaded into the output register.
// Reset:
//   rst (synchronous) sets azimuth and polar to zero, distance to 1.0 and
//   the gains to their defaults; no item is held.
// Stall:
//   If m_axis_tready stays low, the result waits in the output register;
//   the core still accepts the next item but holds its result until taken.
module orbit_camera_position_core
  import ocp_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mouse_dx[15:0] mouse_dy[31:16] wheel_offset[47:32] frame_time[63:48]
  // target_x[95:64] target_y[127:96] target_z[159:128]
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tuser, // target_present
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // eye_x[31:0] eye_y[63:32] eye_z[95:64]
  output logic [95:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] rotation_gain, zoom_gain;
  logic [30:0] min_distance;
  ocp_cmd_t    cmd;
  ocp_status_t status;
  logic signed [31:0] eye_x, eye_y, eye_z;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_gain <= 16'd256;
      zoom_gain     <= 16'd128;
      min_distance  <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROT:  rotation_gain <= pwdata[15:0];
        REG_ZOOM: zoom_gain     <= pwdata[15:0];
        REG_MIN:  min_distance  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT:  prdata = {16'd0, rotation_gain};
      REG_ZOOM: prdata = {16'd0, zoom_gain};
      REG_MIN:  prdata = {1'b0, min_distance};
      default:  prdata = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
    if (cmd.out_load) m_axis_tdata <= {eye_z, eye_y, eye_x};
  end

  assign status.out_full = m_axis_tvalid && !m_axis_tready;

  ocp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ocp_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rotation_gain  (rotation_gain),
    .zoom_gain      (zoom_gain),
    .min_distance   (min_distance),
    .mouse_dx       (s_axis_tdata[15:0]),
    .mouse_dy       (s_axis_tdata[31:16]),
    .wheel_offset   (s_axis_tdata[47:32]),
    .frame_time     (s_axis_tdata[63:48]),
    .target_present (s_axis_tuser),
    .target_x       (s_axis_tdata[95:64]),
    .target_y       (s_axis_tdata[127:96]),
    .target_z       (s_axis_tdata[159:128]),
    .eye_x          (eye_x),
    .eye_y          (eye_y),
    .eye_z          (eye_z)
  );

endmodule

FILE: rtl/ocp_checker.sv
// Port-level checks for the orbit camera position core.
`include "orbit_camera_position_core_defines.svh"
module ocp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        pready
);

  `OCP_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
  `OCP_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "second item taken while busy")
  `OCP_ASSERT_NEXT(a_no_early_result, clk, rst, s_axis_tvalid && s_axis_tready,
    !$rose(m_axis_tvalid), "result appeared without work")
  `OCP_ASSERT_IMP(a_pready, clk, rst, 1'b1, pready, "pready low")

endmodule

bind orbit_camera_position_core ocp_checker u_ocp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

FILE: dv/orbit_camera_position_core_test.sv
// Testbench for the orbit camera position core: directed and random frame items
// checked against a fixed-point model of the orbit update and eye position.
`timescale 1ns / 100ps

module orbit_camera_position_core_test;
  import ocp_pkg::*;

  localparam int ANG_BITS = 16;
  localparam int CLK_HALF = 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;
  localparam longint Q30_ONE = 64'sd1 << 30;

  typedef struct packed {
    logic signed [31:0] tz;
    logic signed [31:0] ty;
    logic signed [31:0] tx;
    logic        [15:0] dt;
    logic signed [15:0] wheel;
    logic signed [15:0] dy;
    logic signed [15:0] dx;
  } frame_data_t;

  typedef struct {
    frame_data_t data;
    logic        has_target;
  } frame_item_t;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } eye_pos_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;   // mouse_dx, mouse_dy, wheel_offset, frame_time, target_x/y/z
  logic         s_axis_tuser;   // target_present
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;   // eye_x, eye_y, eye_z
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  orbit_camera_position_core #(.ANGLE_BITS(ANG_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: registers and orbit state mirrored here.
  longint rot_gain, zm_gain, min_dist;
  longint orbit_az, orbit_pol, orbit_dist;

  frame_item_t pending_frames[$];
  eye_pos_t    expected_eyes[$];
  int          error_count;
  int          accepted_count;
  int          idle_cycles;
  bit          hold_off_req;   // set by stimulus to ask for a long sink stall

  function automatic longint fshift(longint v, int s);
    return v >>> s;   // arithmetic shift is floor for two's complement
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Odd polynomial over a quarter wave, Q30 in and out.
  function automatic longint quarter_wave_sine(longint x);
    longint x2, p;
    x2 = fshift(x * x, 30);
    p = SIN_C9;
    p = -longint'(SIN_C7) + fshift(p * x2, 30);
    p = longint'(SIN_C5) + fshift(p * x2, 30);
    p = -longint'(SIN_C3) + fshift(p * x2, 30);
    p = longint'(SIN_C1) + fshift(p * x2, 30);
    p = fshift(p * x, 30);
    if (p < 0) p = 0;
    if (p > Q30_ONE) p = Q30_ONE;
    return p;
  endfunction

  function automatic longint sine_of_turns(logic [31:0] turns);
    logic [1:0] quad;
    longint frac, s;
    quad = turns[31:30];
    frac = longint'(turns[29:0]);
    s = quad[0] ? quarter_wave_sine(Q30_ONE - frac) : quarter_wave_sine(frac);
    return quad[1] ? -s : s;
  endfunction

  function automatic logic [31:0] angle_turns(longint a);
    logic [31:0] t;
    t = 32'(a) & ((32'd1 << ANG_BITS) - 1);
    return t << (32 - ANG_BITS);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // Advances the orbit by one frame and returns the eye position it gives.
  function automatic eye_pos_t orbit_step(frame_item_t f);
    longint dx, dy, wh, dt, step, sum, margin, cap, sa, ca, sp, cp, pa, pb;
    logic [31:0] at, pt;
    eye_pos_t e;
    dx = f.data.dx; dy = f.data.dy; wh = f.data.wheel; dt = f.data.dt;
    // zoom, clamped to [min_distance, 2^31-1]
    step = fshift(-wh * zm_gain * dt, 8);
    sum = orbit_dist + step;
    if (sum < min_dist) sum = min_dist;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    orbit_dist = sum;
    // polar, clamped a small margin short of a quarter turn
    margin = ((64'sd1 << ANG_BITS) * 64'sd1000000 + 64'sd3141592653) / 64'sd6283185307;
    if (margin < 1) margin = 1;
    cap = (64'sd1 << (ANG_BITS - 2)) - margin;
    step = fshift(dy * rot_gain * dt, 24 - ANG_BITS);
    sum = orbit_pol + step;
    if (sum > cap) sum = cap;
    if (sum < -cap) sum = -cap;
    orbit_pol = sum;
    // azimuth wraps through a full turn
    step = fshift(dx * rot_gain * dt, 24 - ANG_BITS);
    orbit_az = (orbit_az + step) & ((64'sd1 << ANG_BITS) - 1);
    at = angle_turns(orbit_az);
    pt = angle_turns(orbit_pol);
    sa = sine_of_turns(at);
    ca = sine_of_turns(at + 32'h4000_0000);
    sp = sine_of_turns(pt);
    cp = sine_of_turns(pt + 32'h4000_0000);
    pa = rshift(cp * ca, 30);
    pb = rshift(cp * sa, 30);
    pa = rshift(orbit_dist * pa, 30);
    sp = rshift(orbit_dist * sp, 30);
    pb = rshift(orbit_dist * pb, 30);
    if (f.has_target) begin
      pa += f.data.tx;
      sp += f.data.ty;
      pb += f.data.tz;
    end
    e.x = clamp32(pa);
    e.y = clamp32(sp);
    e.z = clamp32(pb);
    return e;
  endfunction

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Handshakes seen at the last rising edge, for the falling-edge processes.
  logic in_fire, out_fire;
  initial begin
    in_fire = 1'b0;
    out_fire = 1'b0;
  end
  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
  end

  // Driver: presents queued items with a random gap after each.
  int src_gap;
  initial src_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_fire) begin
      // item still being offered
    end else if (src_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_frames.size() > 0) begin
      s_axis_tdata <= pending_frames[0].data;
      s_axis_tuser <= pending_frames[0].has_target;
      s_axis_tvalid <= 1'b1;
      void'(pending_frames.pop_front());
      src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Sink ready: per-result random stall, plus one long hold-off on request.
  int sink_wait;
  int hold_count;
  initial begin
    sink_wait = 0;
    hold_count = 0;
  end
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_req && hold_count < 400) begin
      m_axis_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (out_fire) begin
      // result taken at the last edge; draw the next wait
      sink_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      m_axis_tready <= (sink_wait == 0);
    end else if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
      m_axis_tready <= (sink_wait == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted item, checks each accepted result.
  always @(posedge clk) begin
    eye_pos_t got, exp_eye;
    frame_item_t f;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        f.data = s_axis_tdata;
        f.has_target = s_axis_tuser;
        expected_eyes.push_back(orbit_step(f));
        accepted_count <= accepted_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_eyes.size() == 0) begin
          $error("eye result with no item outstanding");
          error_count++;
        end else begin
          exp_eye = expected_eyes.pop_front();
          if (got.x !== exp_eye.x) begin
            $error("eye_x expected %0d got %0d", exp_eye.x, got.x);
            error_count++;
          end
          if (got.y !== exp_eye.y) begin
            $error("eye_y expected %0d got %0d", exp_eye.y, got.y);
            error_count++;
          end
          if (got.z !== exp_eye.z) begin
            $error("eye_z expected %0d got %0d", exp_eye.z, got.z);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either stream.
  always @(posedge clk) begin
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // APB write: setup, then access; register and model update together.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_ROT:  rot_gain = value[15:0];
      REG_ZOOM: zm_gain = value[15:0];
      REG_MIN:  min_dist = value[30:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Waits until every queued item has come back, then lets the core settle.
  task automatic wait_idle();
    while (pending_frames.size() > 0 || s_axis_tvalid || expected_eyes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic frame_item_t make_frame(int dx, int dy, int wh, int dt, bit tp,
                                             int tx, int ty, int tz);
    frame_item_t f;
    f.data.dx = 16'(dx); f.data.dy = 16'(dy); f.data.wheel = 16'(wh);
    f.data.dt = 16'(dt);
    f.data.tx = tx; f.data.ty = ty; f.data.tz = tz;
    f.has_target = tp;
    return f;
  endfunction

  // Mostly small, frame-like movements; sometimes full-range fields.
  function automatic frame_item_t random_frame();
    frame_item_t f;
    f.data = 160'({$urandom, $urandom, $urandom, $urandom, $urandom});
    f.has_target = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) begin
      f.data.dx = 16'($signed(16'($urandom_range(0, 400))) - 16'sd200);
      f.data.dy = 16'($signed(16'($urandom_range(0, 400))) - 16'sd200);
      f.data.wheel = 16'($signed(16'($urandom_range(0, 20))) - 16'sd10);
      f.data.dt = 16'($urandom_range(500, 3000));
    end
    if ($urandom_range(0, 1) == 0) begin
      f.data.tx = $signed(32'($urandom_range(0, 2000000))) - 1000000;
      f.data.ty = $signed(32'($urandom_range(0, 2000000))) - 1000000;
      f.data.tz = $signed(32'($urandom_range(0, 2000000))) - 1000000;
    end
    return f;
  endfunction

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    error_count = 0;
    accepted_count = 0;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    rot_gain = 256; zm_gain = 128; min_dist = 65536;
    orbit_az = 0; orbit_pol = 0; orbit_dist = 65536;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: defaults, no target, zero movement.
    pending_frames.push_back(make_frame(0, 0, 0, 0, 0, 0, 0, 0));
    pending_frames.push_back(make_frame(100, 50, 0, 1000, 1, 65536, -65536, 3 << 16));
    // Field extremes: huge deltas wrap azimuth and clamp polar both ways.
    pending_frames.push_back(make_frame(32767, 32767, 0, 65535, 0, 0, 0, 0));
    pending_frames.push_back(make_frame(-32768, -32768, 0, 65535, 0, 0, 0, 0));
    pending_frames.push_back(make_frame(-32768, 32767, -32768, 65535, 0, 0, 0, 0));
    // Distance saturates at the top, then eye overflow saturates with the target.
    pending_frames.push_back(make_frame(0, 0, -32768, 65535, 0, 0, 0, 0));
    pending_frames.push_back(make_frame(0, 0, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF));
    pending_frames.push_back(make_frame(16384, -16000, 0, 65535, 1, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
    // Zoom back in hard: distance falls but stays above min_distance.
    pending_frames.push_back(make_frame(0, 0, 32767, 65535, 1, -1, -1, -1));
    wait_idle();

    // Extreme registers; raise the minimum so the next item applies it.
    reg_write(REG_ROT, 32'hFFFF);
    reg_write(REG_ZOOM, 32'hFFFF);
    reg_write(REG_MIN, 32'h7FFF_FFFF);
    pending_frames.push_back(make_frame(1, -1, 1, 1, 0, 0, 0, 0));
    pending_frames.push_back(make_frame(32767, 32767, 32767, 65535, 1, 5, 6, 7));
    wait_idle();
    reg_write(REG_ROT, 32'h0);
    reg_write(REG_ZOOM, 32'h0);
    reg_write(REG_MIN, 32'h0);
    pending_frames.push_back(make_frame(-32768, 32767, -32768, 65535, 0, 0, 0, 0));
    pending_frames.push_back(make_frame(0, 0, 0, 65535, 1, 1, 2, 3));
    wait_idle();
    reg_write(REG_ROT, 32'd256);
    reg_write(REG_ZOOM, 32'd128);
    reg_write(REG_MIN, 32'd65536);
    pending_frames.push_back(make_frame(0, 0, 32767, 65535, 0, 0, 0, 0));
    wait_idle();

    // Random phases under several register settings; a long sink stall in one.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        reg_write(REG_ROT, $urandom_range(0, 1024));
        reg_write(REG_ZOOM, $urandom_range(0, 1024));
        reg_write(REG_MIN, ($urandom_range(0, 3) == 0) ? $urandom & 32'h7FFF_FFFF
                                                       : $urandom_range(0, 20 << 16));
      end
      for (int i = 0; i < 106; i++) pending_frames.push_back(random_frame());
      if (ph == 2) hold_off_req = 1'b1;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
